FILE: src/pcih_pkg.sv
// shared constants, types and helper functions for the isolation histogram unit
package pcih_pkg;

  localparam int VERTEX_BINS = 11;
  localparam int ETA_BINS    = 5;
  localparam int COUNT_WIDTH = 32;

  localparam int TABLE_BINS = 11;
  localparam int USED_BINS  = (VERTEX_BINS < TABLE_BINS) ? VERTEX_BINS : TABLE_BINS;
  localparam int ETA_LIMS   = 4;
  localparam int ETA_USED   = (ETA_BINS - 1 < ETA_LIMS) ? ETA_BINS - 1 : ETA_LIMS;
  localparam int AREA_REGS  = 5;

  // field widths
  localparam int PT_W    = 16;
  localparam int ETA_W   = 12;
  localparam int ISO_W   = 16;
  localparam int RHO_W   = 10;
  localparam int NVTX_W  = 8;
  localparam int TRUTH_W = 2;
  localparam int HSEL_W  = 3;
  localparam int BSEL_W  = 4;
  localparam int IETA_W  = 3;
  localparam int VBIN_OUT_W = 4;
  localparam int COUNT_OUT_W = 32;
  localparam int ICUT_W  = 10;
  localparam int AREA_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // internal arithmetic widths
  localparam int VBIN_W = $clog2(VERTEX_BINS + 1);
  localparam int NEU_W  = ISO_W + 1;
  localparam int THR_W  = ICUT_W + PT_W;
  localparam int SUB_W  = RHO_W + AREA_W;
  localparam int CMP_W  = 28;

  // histogram store: one row per (truth group, vertex bin), four counters a row
  localparam int LANES     = 4;
  localparam int LANE_W    = 2;
  localparam int ROW_DEPTH = 2 * VERTEX_BINS;
  localparam int ROW_W     = $clog2(ROW_DEPTH);
  localparam int ROW_BITS  = LANES * COUNT_WIDTH;

  localparam logic [ETA_W-1:0] BOUNDARY_ETA = 12'd1514;
  localparam logic [ETA_W-1:0] MAX_ETA      = 12'd2560;

  localparam logic [ETA_W-1:0] ETA_LIMITS [ETA_LIMS] = '{
    12'd819, 12'd1331, 12'd2048, 12'd2253
  };
  localparam logic [NVTX_W-1:0] VTX_LIMITS [TABLE_BINS+1] = '{
    8'd5, 8'd10, 8'd13, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd22, 8'd25, 8'd30
  };

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [TRUTH_W-1:0] TRUTH_TRUE    = 2'd1;
  localparam logic [TRUTH_W-1:0] TRUTH_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PT_CUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ISO_CUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BARREL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AREA0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AREA2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AREA3   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AREA4   = 3'd7;

  typedef struct packed {
    logic [PT_W-1:0]                     pt_cut;
    logic [ICUT_W-1:0]                   iso_cut;
    logic                                barrel_region;
    logic [AREA_REGS-1:0][AREA_W-1:0]    area;
  } cfg_regs_t;

  // per-candidate selection results handed from stage one to stage two
  typedef struct packed {
    logic               acc;
    logic [IETA_W-1:0]  ieta;
    logic [VBIN_W-1:0]  vbin;
    logic [THR_W-1:0]   thr;
    logic [SUB_W-1:0]   sub;
    logic [NEU_W-1:0]   neu;
    logic [ROW_W-1:0]   row;
    logic [LANE_W-1:0]  lane;
    logic               hit;
  } sel_t;

  function automatic logic [IETA_W-1:0] eta_bin(input logic [ETA_W-1:0] eta);
    logic [IETA_W-1:0] r;
    r = '0;
    for (int i = 0; i < ETA_USED; i++) begin
      if (eta > ETA_LIMITS[i]) r = IETA_W'(i + 1);
    end
    return r;
  endfunction

  // limit ranges are disjoint, so at most one bin matches
  function automatic logic [VBIN_W-1:0] vertex_bin_of(input logic [NVTX_W-1:0] v);
    logic [VBIN_W-1:0] r;
    r = VBIN_W'(VERTEX_BINS);
    for (int i = 0; i < USED_BINS; i++) begin
      if (v >= VTX_LIMITS[i] && v < VTX_LIMITS[i+1]) r = VBIN_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: src/pcih_ifs.sv
// handshake channel interfaces: candidate input, result output, register writes
interface pcih_cand_if;
  import pcih_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [PT_W-1:0]      momentum;
  logic [ETA_W-1:0]     abs_eta;
  logic [ISO_W-1:0]     iso_charged;
  logic [ISO_W-1:0]     iso_neutral;
  logic [ISO_W-1:0]     iso_photon;
  logic [ISO_W-1:0]     iso_pileup;
  logic [RHO_W-1:0]     energy_density;
  logic [NVTX_W-1:0]    vertex_count;
  logic [TRUTH_W-1:0]   truth_class;
  logic [HSEL_W-1:0]    hist_select;
  logic [BSEL_W-1:0]    bin_select;

  modport source (output valid, operation, momentum, abs_eta, iso_charged, iso_neutral,
                  iso_photon, iso_pileup, energy_density, vertex_count, truth_class,
                  hist_select, bin_select, input ready);
  modport sink (input valid, operation, momentum, abs_eta, iso_charged, iso_neutral,
                iso_photon, iso_pileup, energy_density, vertex_count, truth_class,
                hist_select, bin_select, output ready);
endinterface

interface pcih_result_if;
  import pcih_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic [IETA_W-1:0]       eta_index;
  logic [VBIN_OUT_W-1:0]   vertex_bin;
  logic                    pass_raw;
  logic                    pass_dbeta;
  logic                    pass_area;
  logic [COUNT_OUT_W-1:0]  count_value;

  modport source (output valid, accepted, eta_index, vertex_bin, pass_raw, pass_dbeta,
                  pass_area, count_value, input ready);
  modport sink (input valid, accepted, eta_index, vertex_bin, pass_raw, pass_dbeta,
                pass_area, count_value, output ready);
endinterface

interface pcih_cfg_if;
  import pcih_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/pcih_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module pcih_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same row is written in that cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: src/pcih_classify.sv
// stage one: candidate selection, eta and vertex binning, thresholds and row address
module pcih_classify import pcih_pkg::*; (
  input  cfg_regs_t           cfg,
  input  logic                op,
  input  logic [PT_W-1:0]     momentum,
  input  logic [ETA_W-1:0]    abs_eta,
  input  logic [ISO_W-1:0]    iso_neutral,
  input  logic [ISO_W-1:0]    iso_photon,
  input  logic [RHO_W-1:0]    energy_density,
  input  logic [NVTX_W-1:0]   vertex_count,
  input  logic [TRUTH_W-1:0]  truth_class,
  input  logic [HSEL_W-1:0]   hist_select,
  input  logic [BSEL_W-1:0]   bin_select,
  output sel_t                sel
);

  logic               region_ok;
  logic [IETA_W-1:0]  ieta;
  logic [VBIN_W-1:0]  vbin;
  logic               grp;
  logic [ROW_W-1:0]   bin_row;

  always_comb begin
    region_ok = cfg.barrel_region ? (abs_eta < BOUNDARY_ETA) : (abs_eta > BOUNDARY_ETA);
    ieta = eta_bin(abs_eta);
    vbin = vertex_bin_of(vertex_count);

    sel.acc  = (momentum > cfg.pt_cut) && region_ok && (abs_eta <= MAX_ETA);
    sel.ieta = ieta;
    sel.vbin = vbin;
    sel.thr  = THR_W'(cfg.iso_cut) * THR_W'(momentum);
    sel.sub  = SUB_W'(energy_density) * SUB_W'(cfg.area[ieta]);
    sel.neu  = NEU_W'(iso_neutral) + NEU_W'(iso_photon);

    // true electrons fill the first row group, fakes the second
    if (op == OP_READ) begin
      grp      = hist_select[HSEL_W-1];
      bin_row  = ROW_W'(bin_select);
      sel.hit  = int'(bin_select) < VERTEX_BINS;
      sel.lane = hist_select[LANE_W-1:0];
    end else begin
      grp      = truth_class != TRUTH_TRUE;
      bin_row  = ROW_W'(vbin);
      sel.hit  = int'(vbin) < VERTEX_BINS;
      sel.lane = '0;
    end
    if (sel.hit) begin
      sel.row = (grp ? ROW_W'(VERTEX_BINS) : ROW_W'(0)) + bin_row;
    end else begin
      sel.row = '0;
    end
  end

endmodule

FILE: src/pileup_corrected_isolation_histogram_unit.sv
// top level: pileup-corrected isolation monitor with saturating vertex-binned histograms
//
//  channel  modport  holds                                      transfer when
//  cand     sink     operation and candidate/read fields        cand.valid & cand.ready
//  res      source   selection flags, pass flags, count value   res.valid & res.ready
//  cfg      sink     register index and write data              cfg.valid & cfg.ready
//
// one item per cycle sustained while res is not stalled; an item passes the stages in order
// (input stage at the transfer, then selection and ram read, then isolation compare
// and counter update) and its result is registered in the result register.
// the rate is set by the read-modify-write of one histogram row in the second stage;
// a row written in the cycle of the next read is forwarded from the write data.
// reset loads the register defaults and clears the row valid bits, so rows read
// as zero until first written; no clearing pass is needed.
// when res is stalled the result register holds and the stages fill behind it;
// cand.ready falls only once all three stages hold an item. cfg is always ready.
module pileup_corrected_isolation_histogram_unit import pcih_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  pcih_cfg_if.sink      cfg,
  pcih_cand_if.sink     cand,
  pcih_result_if.source res
);

  cfg_regs_t cfg_regs;

  // stage one registers
  logic                s1_v;
  logic                s1_op;
  logic [PT_W-1:0]     s1_pt;
  logic [ETA_W-1:0]    s1_eta;
  logic [ISO_W-1:0]    s1_ch;
  logic [ISO_W-1:0]    s1_nh;
  logic [ISO_W-1:0]    s1_ph;
  logic [ISO_W-1:0]    s1_pu;
  logic [RHO_W-1:0]    s1_rho;
  logic [NVTX_W-1:0]   s1_nvtx;
  logic [TRUTH_W-1:0]  s1_truth;
  logic [HSEL_W-1:0]   s1_hsel;
  logic [BSEL_W-1:0]   s1_bsel;
  sel_t                s1_sel;

  // stage two registers
  logic                s2_v;
  logic                s2_op;
  logic [TRUTH_W-1:0]  s2_truth;
  logic [ISO_W-1:0]    s2_ch;
  logic [ISO_W-1:0]    s2_pu;
  sel_t                s2_sel;
  logic                s2_fwd;
  logic [ROW_BITS-1:0] s2_fwd_data;

  logic s1_go, s2_go, out_free;

  logic                 ram_we;
  logic [ROW_BITS-1:0]  ram_wdata;
  logic [ROW_BITS-1:0]  ram_q;
  logic [ROW_DEPTH-1:0] row_valid;

  logic [17:0]          raw_sum;
  logic [17:0]          two_neu;
  logic [17:0]          dcorr;
  logic [18:0]          ysum;
  logic [26:0]          n1024;
  logic [26:0]          acorr;
  logic [CMP_W-1:0]     xsum;
  logic [CMP_W-1:0]     thr_ext;
  logic                 pr, pd, pa;
  logic                 do_bump;
  logic [LANES-1:0]     lane_hit;
  logic [ROW_BITS-1:0]  cur_row;
  logic [COUNT_WIDTH-1:0] cur_lane;
  logic [COUNT_WIDTH-1:0] rd_lane;

  assign out_free   = !res.valid || res.ready;
  assign s2_go      = s2_v && out_free;
  assign s1_go      = s1_v && (!s2_v || s2_go);
  assign cand.ready = !s1_v || s1_go;
  assign cfg.ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pt_cut        <= 16'd400;
      cfg_regs.iso_cut       <= 10'd102;
      cfg_regs.barrel_region <= 1'b1;
      cfg_regs.area[0]       <= 10'd107;
      cfg_regs.area[1]       <= 10'd106;
      cfg_regs.area[2]       <= 10'd60;
      cfg_regs.area[3]       <= 10'd84;
      cfg_regs.area[4]       <= 10'd159;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PT_CUT:  cfg_regs.pt_cut        <= cfg.data[PT_W-1:0];
        REG_ISO_CUT: cfg_regs.iso_cut       <= cfg.data[ICUT_W-1:0];
        REG_BARREL:  cfg_regs.barrel_region <= cfg.data[0];
        REG_AREA0:   cfg_regs.area[0]       <= cfg.data[AREA_W-1:0];
        REG_AREA1:   cfg_regs.area[1]       <= cfg.data[AREA_W-1:0];
        REG_AREA2:   cfg_regs.area[2]       <= cfg.data[AREA_W-1:0];
        REG_AREA3:   cfg_regs.area[3]       <= cfg.data[AREA_W-1:0];
        REG_AREA4:   cfg_regs.area[4]       <= cfg.data[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // stage one capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (cand.ready) begin
      s1_v <= cand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cand.valid && cand.ready) begin
      s1_op    <= cand.operation;
      s1_pt    <= cand.momentum;
      s1_eta   <= cand.abs_eta;
      s1_ch    <= cand.iso_charged;
      s1_nh    <= cand.iso_neutral;
      s1_ph    <= cand.iso_photon;
      s1_pu    <= cand.iso_pileup;
      s1_rho   <= cand.energy_density;
      s1_nvtx  <= cand.vertex_count;
      s1_truth <= cand.truth_class;
      s1_hsel  <= cand.hist_select;
      s1_bsel  <= cand.bin_select;
    end
  end

  pcih_classify u_classify (
    .cfg            (cfg_regs),
    .op             (s1_op),
    .momentum       (s1_pt),
    .abs_eta        (s1_eta),
    .iso_neutral    (s1_nh),
    .iso_photon     (s1_ph),
    .energy_density (s1_rho),
    .vertex_count   (s1_nvtx),
    .truth_class    (s1_truth),
    .hist_select    (s1_hsel),
    .bin_select     (s1_bsel),
    .sel            (s1_sel)
  );

  pcih_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROW_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_sel.row),
    .wdata (ram_wdata),
    .re    (s1_go),
    .raddr (s1_sel.row),
    .rdata (ram_q)
  );

  // stage two capture; note a same-row write that the ram read will miss
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_go) begin
      s2_v <= 1'b1;
    end else if (s2_go) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_op       <= s1_op;
      s2_truth    <= s1_truth;
      s2_ch       <= s1_ch;
      s2_pu       <= s1_pu;
      s2_sel      <= s1_sel;
      s2_fwd      <= ram_we && (s2_sel.row == s1_sel.row);
      s2_fwd_data <= ram_wdata;
    end
  end

  // isolation compares
  always_comb begin
    thr_ext = CMP_W'(s2_sel.thr);
    raw_sum = 18'(s2_ch) + 18'(s2_sel.neu);
    pr      = {raw_sum, 10'b0} < thr_ext;

    two_neu = {s2_sel.neu, 1'b0};
    dcorr   = (two_neu > 18'(s2_pu)) ? two_neu - 18'(s2_pu) : '0;
    ysum    = 19'({s2_ch, 1'b0}) + 19'(dcorr);
    pd      = {ysum, 9'b0} < thr_ext;

    n1024   = {s2_sel.neu, 10'b0};
    acorr   = (n1024 > 27'(s2_sel.sub)) ? n1024 - 27'(s2_sel.sub) : '0;
    xsum    = CMP_W'({s2_ch, 10'b0}) + CMP_W'(acorr);
    pa      = xsum < thr_ext;
  end

  // row update: denominator lane always, pass lanes by their flag
  always_comb begin
    do_bump  = (s2_op == OP_PROCESS) && s2_sel.acc && s2_sel.hit &&
               (s2_truth != TRUTH_IGNORED);
    lane_hit = {pa, pd, pr, 1'b1};
    if (s2_fwd) begin
      cur_row = s2_fwd_data;
    end else if (row_valid[s2_sel.row]) begin
      cur_row = ram_q;
    end else begin
      cur_row = '0;
    end
    for (int k = 0; k < LANES; k++) begin
      cur_lane = cur_row[k*COUNT_WIDTH +: COUNT_WIDTH];
      if (lane_hit[k] && (cur_lane != '1)) begin
        ram_wdata[k*COUNT_WIDTH +: COUNT_WIDTH] = cur_lane + COUNT_WIDTH'(1);
      end else begin
        ram_wdata[k*COUNT_WIDTH +: COUNT_WIDTH] = cur_lane;
      end
    end
    ram_we  = s2_go && do_bump;
    rd_lane = s2_sel.hit ? cur_row[s2_sel.lane*COUNT_WIDTH +: COUNT_WIDTH] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[s2_sel.row] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      if (s2_op == OP_READ) begin
        res.accepted    <= 1'b0;
        res.eta_index   <= '0;
        res.vertex_bin  <= '0;
        res.pass_raw    <= 1'b0;
        res.pass_dbeta  <= 1'b0;
        res.pass_area   <= 1'b0;
        res.count_value <= COUNT_OUT_W'(rd_lane);
      end else begin
        res.accepted    <= s2_sel.acc;
        res.eta_index   <= s2_sel.ieta;
        res.vertex_bin  <= VBIN_OUT_W'(s2_sel.vbin);
        res.pass_raw    <= pr;
        res.pass_dbeta  <= pd;
        res.pass_area   <= pa;
        res.count_value <= '0;
      end
    end
  end

  // checks
  a_row_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (($past(row_valid) & ~row_valid) == '0))
    else $error("row valid bit cleared outside reset");

  a_no_write_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s2_v && !out_free) |-> !ram_we)
    else $error("histogram row written while stage two is stalled");

  a_accept_has_no_count: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.accepted) |-> (res.count_value == '0))
    else $error("accepted candidate result carries a count value");

  a_empty_is_ready: assert property (@(posedge clk) disable iff (rst)
    (!s1_v && !s2_v) |-> cand.ready)
    else $error("input not ready with empty pipeline");

endmodule
